// ===== src/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master segment sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// item kinds
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_EVENT = 2'd2
	} action_t;

	// completion codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_IO      = 2'd1;
	localparam logic [1:0] ST_RETRY   = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// peripheral status word
	localparam logic [15:0] BUS_IDLE_WORD = 16'h0010;
	localparam logic [15:0] ERR_IO_MASK   = 16'h0405;
	localparam logic [15:0] ERR_ARB_MASK  = 16'h0002;
	localparam logic [15:0] ERR_TO_MASK   = 16'h0340;
	localparam logic [15:0] CLK_HOLD_MASK = 16'h0080;

	// interrupt flag bits
	localparam int FLAG_MB_BIT = 0;
	localparam int FLAG_SB_BIT = 1;

	// what the result register is loaded with
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_REJECT,
		RES_ADDR,
		RES_ERROR,
		RES_END,
		RES_BYTE
	} res_kind_t;

	// which table entry is read
	typedef enum logic [1:0] {
		RD_CUR,
		RD_NEXT,
		RD_FIRST
	} rd_sel_t;

	typedef struct packed {
		logic      capture;
		logic      wr_en;
		logic      open_xfer;
		rd_sel_t   rd_sel;
		logic      seg_step;
		logic      advance;
		logic      emit;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       start_ok;
		logic       count_zero;
		logic       event_ok;
		logic       error_hit;
		logic       exhausted;
		logic       last_seg;
		logic       dir_change;
	} dp_stat_t;

endpackage

// ===== src/i2c_master_segment_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_segment_sequencer_unit
// I2C master transfer sequencer over a table of direction/length segments.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and must be captured then.
// After the capture, a segment load, a rejected or empty start, a spurious
// event and an error completion are answered from the decode state; a start
// with segments is answered once table entry 0 has been read; a data event
// is answered once the current entry has been read, and every exhausted
// segment skipped adds a read and a check of the entry at the incremented
// index. An exhausted last segment ends the transfer normally; a repeated
// start is issued once the entry that changes the direction has been read.
// busy drops while done is high, so the next item can be taken at the edge
// that takes the result.
// The segment table sits in a RAM with one registered read port, so each
// table lookup is registered before it is used. Loads may be issued at any
// time, also while a transfer is running.
module i2c_master_segment_sequencer_unit #(
	parameter int MAX_SEGMENTS = 8,
	parameter int LENGTH_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  action,
	input  logic [2:0]  segment_slot,
	input  logic [15:0] segment_length,
	input  logic        segment_is_read,
	input  logic [6:0]  target_address,
	input  logic [3:0]  segment_count,
	input  logic [7:0]  interrupt_flags,
	input  logic [15:0] bus_status,
	input  logic [7:0]  tx_byte,
	input  logic [7:0]  rx_byte,
	output logic [1:0]  status_code,
	output logic        address_write,
	output logic [7:0]  address_byte,
	output logic        data_write,
	output logic [7:0]  data_out,
	output logic        data_read,
	output logic [7:0]  read_value,
	output logic        send_nack,
	output logic        send_stop,
	output logic        transfer_done,
	output logic [2:0]  segment_index,
	output logic [15:0] byte_offset
);
	import i2cms_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	i2cms_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	i2cms_dp #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.segment_slot   (segment_slot),
		.segment_length (segment_length),
		.segment_is_read(segment_is_read),
		.target_address (target_address),
		.segment_count  (segment_count),
		.interrupt_flags(interrupt_flags),
		.bus_status     (bus_status),
		.tx_byte        (tx_byte),
		.rx_byte        (rx_byte),
		.status_code    (status_code),
		.address_write  (address_write),
		.address_byte   (address_byte),
		.data_write     (data_write),
		.data_out       (data_out),
		.data_read      (data_read),
		.read_value     (read_value),
		.send_nack      (send_nack),
		.send_stop      (send_stop),
		.transfer_done  (transfer_done),
		.segment_index  (segment_index),
		.byte_offset    (byte_offset)
	);

endmodule

// ===== src/i2cms_ram.sv =====
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/i2cms_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cms_ctrl
// Controller state machine: walks one item through decode, table reads and
// segment skipping, and fires the result strobe.
// ----------------------------------------------------------------------------
module i2cms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  i2cms_pkg::dp_stat_t stat,
	output i2cms_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import i2cms_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FIRST,
		S_CHECK,
		S_NEXT
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_CUR;
		cmd.kind   = RES_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.action)
					ACT_LOAD: begin
						cmd.wr_en = 1'b1;
						cmd.emit  = 1'b1;
						state_d   = S_IDLE;
					end
					ACT_START: begin
						if (!stat.start_ok) begin
							cmd.emit = 1'b1;
							cmd.kind = RES_REJECT;
							state_d  = S_IDLE;
						end else if (stat.count_zero) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end else begin
							cmd.open_xfer = 1'b1;
							cmd.rd_sel    = RD_FIRST;
							state_d       = S_FIRST;
						end
					end
					ACT_EVENT: begin
						if (!stat.event_ok) begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end else if (stat.error_hit) begin
							cmd.emit = 1'b1;
							cmd.kind = RES_ERROR;
							state_d  = S_IDLE;
						end else begin
							cmd.rd_sel = RD_CUR;
							state_d    = S_CHECK;
						end
					end
					default: begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				endcase
			end
			// entry 0 is on the read port: address byte of the start
			S_FIRST: begin
				cmd.emit = 1'b1;
				cmd.kind = RES_ADDR;
				state_d  = S_IDLE;
			end
			// current entry is on the read port
			S_CHECK: begin
				if (!stat.exhausted) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_BYTE;
					state_d  = S_IDLE;
				end else begin
					cmd.seg_step = 1'b1;
					if (stat.last_seg) begin
						cmd.emit = 1'b1;
						cmd.kind = RES_END;
						state_d  = S_IDLE;
					end else begin
						cmd.rd_sel = RD_NEXT;
						state_d    = S_NEXT;
					end
				end
			end
			// following entry is on the read port
			S_NEXT: begin
				cmd.advance = 1'b1;
				if (stat.dir_change) begin
					cmd.emit = 1'b1;
					cmd.kind = RES_ADDR;
					state_d  = S_IDLE;
				end else begin
					// re-read the new current entry
					cmd.rd_sel = RD_NEXT;
					state_d    = S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ===== src/i2cms_dp.sv =====
// ----------------------------------------------------------------------------
// i2cms_dp
// Datapath: item capture, transfer registers, segment table and the result
// register.
// ----------------------------------------------------------------------------
module i2cms_dp #(
	parameter int MAX_SEGMENTS = 8,
	parameter int LENGTH_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cms_pkg::dp_cmd_t  cmd,
	output i2cms_pkg::dp_stat_t stat,
	input  logic [1:0]          action,
	input  logic [2:0]          segment_slot,
	input  logic [15:0]         segment_length,
	input  logic                segment_is_read,
	input  logic [6:0]          target_address,
	input  logic [3:0]          segment_count,
	input  logic [7:0]          interrupt_flags,
	input  logic [15:0]         bus_status,
	input  logic [7:0]          tx_byte,
	input  logic [7:0]          rx_byte,
	output logic [1:0]          status_code,
	output logic                address_write,
	output logic [7:0]          address_byte,
	output logic                data_write,
	output logic [7:0]          data_out,
	output logic                data_read,
	output logic [7:0]          read_value,
	output logic                send_nack,
	output logic                send_stop,
	output logic                transfer_done,
	output logic [2:0]          segment_index,
	output logic [15:0]         byte_offset
);
	import i2cms_pkg::*;

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int ENT_W = LENGTH_BITS + 1;

	// captured item
	logic [1:0]  action_q;
	logic [2:0]  slot_q;
	logic [15:0] length_q;
	logic        is_read_q;
	logic [6:0]  addr_in_q;
	logic [3:0]  count_q;
	logic [7:0]  flags_q;
	logic [15:0] bus_q;
	logic [7:0]  tx_q;
	logic [7:0]  rx_q;

	// transfer state
	logic                   active_q;
	logic [6:0]             slave_q;
	logic [IDX_W-1:0]       cur_q;
	logic [CNT_W-1:0]       left_q;
	logic [LENGTH_BITS-1:0] off_q;
	logic                   dir_q;

	// table
	logic [IDX_W-1:0]       rd_addr;
	logic [ENT_W-1:0]       rd_data;
	logic [LENGTH_BITS-1:0] rd_len;
	logic                   rd_dir;
	logic                   slot_ok;
	logic [CNT_W-1:0]       count_sat;
	logic [1:0]             err_code;
	logic                   move_wr;
	logic                   move_rd;
	logic                   clear_xfer;

	// result register
	logic [1:0]  status_code_q;
	logic        address_write_q;
	logic [7:0]  address_byte_q;
	logic        data_write_q;
	logic [7:0]  data_out_q;
	logic        data_read_q;
	logic [7:0]  read_value_q;
	logic        send_nack_q;
	logic        send_stop_q;
	logic        transfer_done_q;
	logic [2:0]  segment_index_q;
	logic [15:0] byte_offset_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			slot_q    <= segment_slot;
			length_q  <= segment_length;
			is_read_q <= segment_is_read;
			addr_in_q <= target_address;
			count_q   <= segment_count;
			flags_q   <= interrupt_flags;
			bus_q     <= bus_status;
			tx_q      <= tx_byte;
			rx_q      <= rx_byte;
		end
	end

	// segment table
	always_comb begin
		case (cmd.rd_sel)
			RD_NEXT:  rd_addr = cur_q + IDX_W'(1);
			RD_FIRST: rd_addr = '0;
			default:  rd_addr = cur_q;
		endcase
	end

	assign slot_ok = (32'(slot_q) < MAX_SEGMENTS);

	i2cms_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_SEGMENTS)
	) u_table (
		.clk    (clk),
		.wr_en  (cmd.wr_en && slot_ok),
		.wr_addr(IDX_W'(slot_q)),
		.wr_data({is_read_q, LENGTH_BITS'(length_q)}),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_len = rd_data[LENGTH_BITS-1:0];
	assign rd_dir = rd_data[LENGTH_BITS];

	// decode
	assign count_sat = (32'(count_q) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : CNT_W'(count_q);

	always_comb begin
		if ((bus_q & ERR_IO_MASK) != '0) begin
			err_code = ST_IO;
		end else if ((bus_q & ERR_ARB_MASK) != '0) begin
			err_code = ST_RETRY;
		end else if ((bus_q & ERR_TO_MASK) != '0) begin
			err_code = ST_TIMEOUT;
		end else begin
			err_code = ST_OK;
		end
	end

	assign move_wr = flags_q[FLAG_MB_BIT] && !rd_dir;
	assign move_rd = flags_q[FLAG_SB_BIT] && rd_dir;

	assign stat.action     = action_q;
	assign stat.start_ok   = !active_q && (bus_q == BUS_IDLE_WORD);
	assign stat.count_zero = (count_q == '0);
	assign stat.event_ok   = (flags_q != '0) && active_q && (left_q != '0);
	assign stat.error_hit  = (err_code != ST_OK);
	assign stat.exhausted  = (off_q >= rd_len);
	assign stat.last_seg   = (left_q == CNT_W'(1));
	assign stat.dir_change = (rd_dir != dir_q);

	assign clear_xfer = cmd.emit && ((cmd.kind == RES_ERROR) || (cmd.kind == RES_END));

	// transfer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slave_q  <= '0;
			cur_q    <= '0;
			left_q   <= '0;
			off_q    <= '0;
			dir_q    <= 1'b0;
		end else begin
			if (clear_xfer) begin
				active_q <= 1'b0;
				slave_q  <= '0;
				cur_q    <= '0;
				left_q   <= '0;
				off_q    <= '0;
			end else if (cmd.open_xfer) begin
				active_q <= 1'b1;
				slave_q  <= addr_in_q;
				cur_q    <= '0;
				left_q   <= count_sat;
				off_q    <= '0;
			end else begin
				if (cmd.seg_step) begin
					left_q <= left_q - CNT_W'(1);
					dir_q  <= rd_dir;
				end
				if (cmd.advance) begin
					cur_q <= cur_q + IDX_W'(1);
					off_q <= '0;
				end
				if (cmd.emit && (cmd.kind == RES_BYTE) && (move_wr || move_rd)) begin
					off_q <= off_q + LENGTH_BITS'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_code_q   <= ST_OK;
			address_write_q <= 1'b0;
			address_byte_q  <= '0;
			data_write_q    <= 1'b0;
			data_out_q      <= '0;
			data_read_q     <= 1'b0;
			read_value_q    <= '0;
			send_nack_q     <= 1'b0;
			send_stop_q     <= 1'b0;
			transfer_done_q <= 1'b0;
			segment_index_q <= '0;
			byte_offset_q   <= '0;
			case (cmd.kind)
				RES_REJECT: begin
					status_code_q <= ST_RETRY;
				end
				RES_ADDR: begin
					address_write_q <= 1'b1;
					address_byte_q  <= {slave_q, rd_dir};
				end
				RES_ERROR: begin
					status_code_q   <= err_code;
					send_stop_q     <= ((bus_q & CLK_HOLD_MASK) != '0);
					transfer_done_q <= 1'b1;
				end
				RES_END: begin
					send_stop_q     <= 1'b1;
					transfer_done_q <= 1'b1;
				end
				RES_BYTE: begin
					if (move_wr) begin
						data_write_q    <= 1'b1;
						data_out_q      <= tx_q;
						segment_index_q <= 3'(cur_q);
						byte_offset_q   <= 16'(off_q);
					end else if (move_rd) begin
						data_read_q     <= 1'b1;
						read_value_q    <= rx_q;
						segment_index_q <= 3'(cur_q);
						byte_offset_q   <= 16'(off_q);
						send_nack_q     <= ((rd_len - off_q) == LENGTH_BITS'(1))
							&& (left_q == CNT_W'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status_code   = status_code_q;
	assign address_write = address_write_q;
	assign address_byte  = address_byte_q;
	assign data_write    = data_write_q;
	assign data_out      = data_out_q;
	assign data_read     = data_read_q;
	assign read_value    = read_value_q;
	assign send_nack     = send_nack_q;
	assign send_stop     = send_stop_q;
	assign transfer_done = transfer_done_q;
	assign segment_index = segment_index_q;
	assign byte_offset   = byte_offset_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master segment sequencer. A class keeps its
// own copy of the transfer state and the segment table, computes the one
// result owed for each accepted item and compares the strobed results field
// by field. Directed items cover every item kind and error path; random
// transfers load a table, start, and run interrupt events to completion,
// mixed with noise, errors and loads during a transfer.
// ----------------------------------------------------------------------------
module tb;
	import i2cms_pkg::*;

	localparam int         MAX_SEG     = 8;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam logic [15:0] WORD_NO_ERR = 16'hF8B8;	// status bits that are not errors

	typedef struct {
		logic [1:0]  action;
		logic [2:0]  segment_slot;
		logic [15:0] segment_length;
		logic        segment_is_read;
		logic [6:0]  target_address;
		logic [3:0]  segment_count;
		logic [7:0]  interrupt_flags;
		logic [15:0] bus_status;
		logic [7:0]  tx_byte;
		logic [7:0]  rx_byte;
	} xfer_item_t;

	typedef struct packed {
		logic [1:0]  status_code;
		logic        address_write;
		logic [7:0]  address_byte;
		logic        data_write;
		logic [7:0]  data_out;
		logic        data_read;
		logic [7:0]  read_value;
		logic        send_nack;
		logic        send_stop;
		logic        transfer_done;
		logic [2:0]  segment_index;
		logic [15:0] byte_offset;
	} xfer_result_t;

	// transfer state tracker and result checker
	class transfer_scoreboard;
		bit           xfer_on;
		logic [6:0]   slave_addr;
		int           cur_seg;
		int           segs_left;
		int           offset;
		int           len_tab [MAX_SEG];
		bit           dir_tab [MAX_SEG];
		xfer_result_t owed_results [$];
		int           errors;

		function void clear_xfer();
			xfer_on    = 1'b0;
			slave_addr = '0;
			cur_seg    = 0;
			segs_left  = 0;
			offset     = 0;
		endfunction

		function bit dir_at(int idx);
			return (idx < MAX_SEG) ? dir_tab[idx] : 1'b0;
		endfunction

		// advance the sequencer by one item and return the result it causes
		function xfer_result_t sequence_item(xfer_item_t it);
			xfer_result_t r;
			int           cnt;
			logic [1:0]   code;
			bit           dir;
			r = '0;
			if (it.action == ACT_LOAD) begin
				len_tab[it.segment_slot] = int'(it.segment_length);
				dir_tab[it.segment_slot] = it.segment_is_read;
			end else if (it.action == ACT_START) begin
				cnt = int'(it.segment_count);
				if (xfer_on || it.bus_status != BUS_IDLE_WORD) begin
					r.status_code = ST_RETRY;
				end else if (cnt != 0) begin
					if (cnt > MAX_SEG)
						cnt = MAX_SEG;
					xfer_on    = 1'b1;
					slave_addr = it.target_address;
					cur_seg    = 0;
					segs_left  = cnt;
					offset     = 0;
					r.address_write = 1'b1;
					r.address_byte  = {slave_addr, dir_at(0)};
				end
			end else if (it.action == ACT_EVENT && it.interrupt_flags != '0 && xfer_on
					&& segs_left != 0) begin
				// error bits win, io over arbitration over timeout
				code = ST_OK;
				if ((it.bus_status & ERR_IO_MASK) != '0)
					code = ST_IO;
				else if ((it.bus_status & ERR_ARB_MASK) != '0)
					code = ST_RETRY;
				else if ((it.bus_status & ERR_TO_MASK) != '0)
					code = ST_TIMEOUT;
				if (code != ST_OK) begin
					r.status_code   = code;
					r.send_stop     = (it.bus_status & CLK_HOLD_MASK) != '0;
					r.transfer_done = 1'b1;
					clear_xfer();
					return r;
				end
				// skip exhausted segments
				while (offset >= len_tab[cur_seg]) begin
					segs_left--;
					if (segs_left == 0) begin
						r.send_stop     = 1'b1;
						r.transfer_done = 1'b1;
						clear_xfer();
						return r;
					end
					if (dir_at(cur_seg) != dir_at(cur_seg + 1)) begin
						cur_seg++;
						offset = 0;
						r.address_write = 1'b1;
						r.address_byte  = {slave_addr, dir_at(cur_seg)};
						return r;
					end
					cur_seg++;
					offset = 0;
				end
				// move one data byte
				dir = dir_at(cur_seg);
				if (it.interrupt_flags[FLAG_MB_BIT] && !dir) begin
					r.data_write    = 1'b1;
					r.data_out      = it.tx_byte;
					r.segment_index = 3'(cur_seg);
					r.byte_offset   = 16'(offset);
					offset++;
				end else if (it.interrupt_flags[FLAG_SB_BIT] && dir) begin
					r.send_nack     = (len_tab[cur_seg] - offset == 1) && (segs_left == 1);
					r.data_read     = 1'b1;
					r.read_value    = it.rx_byte;
					r.segment_index = 3'(cur_seg);
					r.byte_offset   = 16'(offset);
					offset++;
				end
			end
			return r;
		endfunction

		function void note_item(xfer_item_t it);
			owed_results.push_back(sequence_item(it));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(xfer_result_t got);
			xfer_result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: result with none outstanding, expected none actual %h",
					$time, got);
				return;
			end
			want = owed_results.pop_front();
			compare_field("status_code",   32'(want.status_code),   32'(got.status_code));
			compare_field("address_write", 32'(want.address_write), 32'(got.address_write));
			compare_field("address_byte",  32'(want.address_byte),  32'(got.address_byte));
			compare_field("data_write",    32'(want.data_write),    32'(got.data_write));
			compare_field("data_out",      32'(want.data_out),      32'(got.data_out));
			compare_field("data_read",     32'(want.data_read),     32'(got.data_read));
			compare_field("read_value",    32'(want.read_value),    32'(got.read_value));
			compare_field("send_nack",     32'(want.send_nack),     32'(got.send_nack));
			compare_field("send_stop",     32'(want.send_stop),     32'(got.send_stop));
			compare_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
			compare_field("segment_index", 32'(want.segment_index), 32'(got.segment_index));
			compare_field("byte_offset",   32'(want.byte_offset),   32'(got.byte_offset));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic [1:0]  action;
	logic [2:0]  segment_slot;
	logic [15:0] segment_length;
	logic        segment_is_read;
	logic [6:0]  target_address;
	logic [3:0]  segment_count;
	logic [7:0]  interrupt_flags;
	logic [15:0] bus_status;
	logic [7:0]  tx_byte;
	logic [7:0]  rx_byte;
	logic [1:0]  status_code;
	logic        address_write;
	logic [7:0]  address_byte;
	logic        data_write;
	logic [7:0]  data_out;
	logic        data_read;
	logic [7:0]  read_value;
	logic        send_nack;
	logic        send_stop;
	logic        transfer_done;
	logic [2:0]  segment_index;
	logic [15:0] byte_offset;

	transfer_scoreboard sb;
	int                 items_sent;

	i2c_master_segment_sequencer_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.done            (done),
		.action          (action),
		.segment_slot    (segment_slot),
		.segment_length  (segment_length),
		.segment_is_read (segment_is_read),
		.target_address  (target_address),
		.segment_count   (segment_count),
		.interrupt_flags (interrupt_flags),
		.bus_status      (bus_status),
		.tx_byte         (tx_byte),
		.rx_byte         (rx_byte),
		.status_code     (status_code),
		.address_write   (address_write),
		.address_byte    (address_byte),
		.data_write      (data_write),
		.data_out        (data_out),
		.data_read       (data_read),
		.read_value      (read_value),
		.send_nack       (send_nack),
		.send_stop       (send_stop),
		.transfer_done   (transfer_done),
		.segment_index   (segment_index),
		.byte_offset     (byte_offset)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// results are strobed for one cycle; take them at the closing edge
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(xfer_result_t'({status_code, address_write, address_byte,
				data_write, data_out, data_read, read_value, send_nack, send_stop,
				transfer_done, segment_index, byte_offset}));
	end

	// idle gaps come with odds of 31 in 100 at each try, but never while items 700 to 999 are sent
	function automatic bit take_gap();
		return !(items_sent >= 700 && items_sent < 1000) && ($urandom_range(0, 99) < 31);
	endfunction

	function automatic xfer_item_t any_item(logic [1:0] act);
		xfer_item_t it;
		it.action          = act;
		it.segment_slot    = 3'($urandom);
		it.segment_length  = 16'($urandom);
		it.segment_is_read = 1'($urandom);
		it.target_address  = 7'($urandom);
		it.segment_count   = 4'($urandom);
		it.interrupt_flags = 8'($urandom);
		it.bus_status      = 16'($urandom);
		it.tx_byte         = 8'($urandom);
		it.rx_byte         = 8'($urandom);
		return it;
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 19))
			0:       return $urandom_range(0, 65535);
			1, 2:    return $urandom_range(4, 8);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	// status word with one error bit forced on
	function automatic logic [15:0] error_word();
		logic [15:0] w;
		w = 16'($urandom);
		case ($urandom_range(0, 6))
			0:       w[0]  = 1'b1;
			1:       w[2]  = 1'b1;
			2:       w[10] = 1'b1;
			3:       w[1]  = 1'b1;
			4:       w[6]  = 1'b1;
			5:       w[8]  = 1'b1;
			default: w[9]  = 1'b1;
		endcase
		return w;
	endfunction

	// drive one item and hold it until the block takes it
	task automatic issue(input xfer_item_t it);
		while (take_gap()) begin
			start <= 1'b0;
			@(posedge clk);
		end
		action          <= it.action;
		segment_slot    <= it.segment_slot;
		segment_length  <= it.segment_length;
		segment_is_read <= it.segment_is_read;
		target_address  <= it.target_address;
		segment_count   <= it.segment_count;
		interrupt_flags <= it.interrupt_flags;
		bus_status      <= it.bus_status;
		tx_byte         <= it.tx_byte;
		rx_byte         <= it.rx_byte;
		start           <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(it);
		if (it.action != ACT_UNKNOWN)
			items_sent++;
	endtask

	task automatic send_load(input int slot, input int len, input bit rd);
		xfer_item_t it;
		it = any_item(ACT_LOAD);
		it.segment_slot    = 3'(slot);
		it.segment_length  = 16'(len);
		it.segment_is_read = rd;
		issue(it);
	endtask

	task automatic send_start(input logic [6:0] addr, input logic [3:0] cnt,
			input logic [15:0] status);
		xfer_item_t it;
		it = any_item(ACT_START);
		it.target_address = addr;
		it.segment_count  = cnt;
		it.bus_status     = status;
		issue(it);
	endtask

	task automatic send_event(input logic [7:0] flags, input logic [15:0] status,
			input logic [7:0] tx, input logic [7:0] rx);
		xfer_item_t it;
		it = any_item(ACT_EVENT);
		it.interrupt_flags = flags;
		it.bus_status      = status;
		it.tx_byte         = tx;
		it.rx_byte         = rx;
		issue(it);
	endtask

	// any item kind with random content
	task automatic send_noise();
		xfer_item_t it;
		it = any_item(2'($urandom_range(0, 3)));
		if (it.action == ACT_START && $urandom_range(0, 3) == 0)
			it.bus_status = BUS_IDLE_WORD;
		if (it.action == ACT_EVENT && $urandom_range(0, 3) == 0)
			it.interrupt_flags = '0;
		if (it.action == ACT_LOAD)
			it.segment_length = 16'(pick_len());
		issue(it);
	endtask

	// hold off until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed_results.size() != 0);
	endtask

	// load a table, start, and run events until the transfer ends
	task automatic run_transfer();
		int         nseg;
		int         nev;
		int         pick;
		logic [3:0] cnt;
		logic [7:0] match;
		nseg = $urandom_range(1, MAX_SEG);
		if ($urandom_range(0, 5) != 0)
			for (int s = 0; s < nseg; s++)
				send_load(s, pick_len(), 1'($urandom_range(0, 1)));
		pick = $urandom_range(0, 29);
		if (pick == 0)
			cnt = '0;
		else if (pick == 1)
			cnt = 4'($urandom_range(MAX_SEG + 1, 15));
		else
			cnt = 4'(nseg);
		send_start(7'($urandom), cnt, BUS_IDLE_WORD);
		nev = 0;
		while (sb.xfer_on && nev < 40) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_event(8'($urandom_range(1, 255)), error_word(), 8'($urandom),
					8'($urandom));
			end else if (pick < 9) begin
				send_noise();
			end else begin
				// mostly both bus flags; sometimes only the one for this segment
				if ($urandom_range(0, 4) == 0)
					match = sb.dir_tab[sb.cur_seg] ? 8'h02 : 8'h01;
				else
					match = 8'h03;
				send_event((8'($urandom) & 8'hFC) | match, 16'($urandom) & WORD_NO_ERR,
					8'($urandom), 8'($urandom));
			end
			nev++;
		end
		// stuck on a long segment: end it with an error
		if (sb.xfer_on)
			send_event(8'h01 | 8'($urandom), error_word(), 8'($urandom), 8'($urandom));
	endtask

	// run limit
	initial begin
		#5_000_000;
		$display("i2c_master_segment_sequencer_unit: mismatch");
		$finish;
	end

	initial begin
		int wait_cycles;
		sb              = new();
		items_sent      = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		action          = ACT_LOAD;
		segment_slot    = '0;
		segment_length  = '0;
		segment_is_read = 1'b0;
		target_address  = '0;
		segment_count   = '0;
		interrupt_flags = '0;
		bus_status      = '0;
		tx_byte         = '0;
		rx_byte         = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill the whole table, largest length in the last slot
		send_load(0, 1, 1'b0);
		send_load(1, 2, 1'b1);
		send_load(2, 0, 1'b1);
		send_load(3, 1, 1'b0);
		send_load(4, 0, 1'b0);
		send_load(5, 1, 1'b1);
		send_load(6, 3, 1'b0);
		send_load(7, 16'hFFFF, 1'b1);

		// unknown kind, event while idle, bad bus state, empty start
		issue(any_item(ACT_UNKNOWN));
		send_event(8'hFF, 16'h0000, 8'h00, 8'h00);
		send_start(7'h12, 4'd1, 16'h0000);
		send_start(7'h12, 4'd0, BUS_IDLE_WORD);

		// write one byte, repeated start, read two with NACK, stop
		send_start(7'h7F, 4'd2, BUS_IDLE_WORD);
		send_start(7'h01, 4'd1, BUS_IDLE_WORD);
		send_event(8'h00, 16'h0000, 8'h00, 8'h00);
		send_event(8'h02, 16'h0000, 8'h33, 8'h44);
		send_event(8'h01, 16'h0000, 8'hFF, 8'h00);
		send_event(8'h03, 16'h0000, 8'h00, 8'h00);
		send_event(8'h02, 16'h0000, 8'hFF, 8'h00);
		send_event(8'h02, 16'h0000, 8'h00, 8'hA5);
		send_event(8'h80, 16'h0000, 8'h00, 8'h00);

		// oversized count, then io beats arbitration, clock held
		send_start(7'h00, 4'd15, BUS_IDLE_WORD);
		send_event(8'h01, 16'h0487, 8'h00, 8'h00);
		// arbitration beats timeout, clock free
		send_start(7'h55, 4'd4, BUS_IDLE_WORD);
		send_event(8'h02, 16'h0342, 8'h00, 8'h00);
		// timeout alone, clock held
		send_start(7'h2A, 4'd1, BUS_IDLE_WORD);
		send_event(8'h01, 16'h03C0, 8'h00, 8'h00);
		drain();

		// random transfers
		while (items_sent < 1650) begin
			run_transfer();
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		// wind down
		start <= 1'b0;
		for (wait_cycles = 0; wait_cycles < 5000 && sb.owed_results.size() != 0;
				wait_cycles++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.owed_results.size() == 0) begin
			$display("i2c_master_segment_sequencer_unit: match");
		end else begin
			if (sb.owed_results.size() != 0)
				$display("%0t: %0d results never arrived", $time, sb.owed_results.size());
			$display("i2c_master_segment_sequencer_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/i2cms_pkg.sv
src/i2cms_ram.sv
src/i2cms_ctrl.sv
src/i2cms_dp.sv
src/i2c_master_segment_sequencer_unit.sv
tb/tb.sv
